// File: rtl/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
`default_nettype none

package sfs_pkg;

   localparam int unsigned DUR_W = 16;
   localparam logic [15:0] SPEED_RESET = 16'd256;

   typedef enum logic [3:0] {
      CMD_TICK         = 4'd0,
      CMD_PLAY         = 4'd1,
      CMD_PLAY_RESTART = 4'd2,
      CMD_STOP         = 4'd3,
      CMD_PAUSE        = 4'd4,
      CMD_RESUME       = 4'd5,
      CMD_RESTART      = 4'd6,
      CMD_WRITE_DUR    = 4'd7,
      CMD_WRITE_CLIP   = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_STOPPED  = 2'd0,
      MODE_PLAYING  = 2'd1,
      MODE_PAUSED   = 2'd2,
      MODE_FINISHED = 2'd3
   } mode_type;

   typedef struct packed {
      logic        ok;
      logic [1:0]  play_state;
      logic [3:0]  current_clip;
      logic [5:0]  frame_index;
      logic [31:0] elapsed_ms;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/sfs_if.sv
// Request and response channel interfaces of the sprite frame sequencer.
`default_nettype none

interface sfs_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command;
   logic [3:0]  clip_id;
   logic [5:0]  frame_slot;
   logic [15:0] delta_ms;
   logic [15:0] table_value;
   logic        loop_flag;

   modport source (output valid, command, clip_id, frame_slot, delta_ms, table_value,
                   loop_flag, input ready);
   modport sink (input valid, command, clip_id, frame_slot, delta_ms, table_value,
                 loop_flag, output ready);
endinterface

interface sfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [1:0]  play_state;
   logic [3:0]  current_clip;
   logic [5:0]  frame_index;
   logic [31:0] elapsed_ms;

   modport source (output valid, ok, play_state, current_clip, frame_index, elapsed_ms,
                   input ready);
   modport sink (input valid, ok, play_state, current_clip, frame_index, elapsed_ms,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/sfs_clip_mem.sv
// Clip descriptor table: frame count and loop flag per clip, with per-entry valid bits.
`default_nettype none

module sfs_clip_mem #(
   parameter int unsigned NUM_CLIPS  = 16,
   parameter int unsigned MAX_FRAMES = 64,
   localparam int unsigned CLIP_W = $clog2(NUM_CLIPS),
   localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CLIP_W-1:0] rd_addr,
   output logic      [CNT_W-1:0]  rd_count,
   output logic                   rd_loop,
   input  wire logic              wr_en,
   input  wire logic [CLIP_W-1:0] wr_addr,
   input  wire logic [CNT_W-1:0]  wr_count,
   input  wire logic              wr_loop
);

   logic [CNT_W-1:0]     count_mem [NUM_CLIPS];
   logic                 loop_mem  [NUM_CLIPS];
   logic [NUM_CLIPS-1:0] valid_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 loop_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_count;
         loop_mem[wr_addr]  <= wr_loop;
      end
      count_ff <= count_mem[rd_addr];
      loop_ff  <= loop_mem[rd_addr];
      hit_ff   <= valid_ff[rd_addr];
   end

   // An entry never written reads as an empty, non-looping clip.
   assign rd_count = hit_ff ? count_ff : '0;
   assign rd_loop  = hit_ff & loop_ff;

endmodule

`default_nettype wire

// File: rtl/sfs_dur_mem.sv
// Frame duration RAM, one write port and one registered read port.
`default_nettype none

module sfs_dur_mem #(
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  wire logic                     clock,
   input  wire logic [AW-1:0]            rd_addr,
   output logic      [sfs_pkg::DUR_W-1:0] rd_data,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [sfs_pkg::DUR_W-1:0] wr_data
);

   logic [sfs_pkg::DUR_W-1:0] mem [DEPTH];
   logic [sfs_pkg::DUR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/sfs_ctrl.sv
// Command sequencer: playback state, time scaling and the bounded frame walk.
`default_nettype none

module sfs_ctrl #(
   parameter int unsigned NUM_CLIPS          = 16,
   parameter int unsigned MAX_FRAMES         = 64,
   parameter int unsigned MAX_STEPS_PER_TICK = 64,
   localparam int unsigned CLIP_W  = $clog2(NUM_CLIPS),
   localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1),
   localparam int unsigned FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   localparam int unsigned AW      = $clog2(NUM_CLIPS * MAX_FRAMES),
   localparam int unsigned STEP_W  = $clog2(MAX_STEPS_PER_TICK + 1)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [15:0]               csr_wr_data,
   sfs_req_if.sink                        req,
   output logic                           result_valid,
   output sfs_pkg::rsp_type               result,
   input  wire logic                      result_load,
   output logic      [CLIP_W-1:0]         clip_rd_addr,
   input  wire logic [CNT_W-1:0]          clip_rd_count,
   input  wire logic                      clip_rd_loop,
   output logic                           clip_wr_en,
   output logic      [CLIP_W-1:0]         clip_wr_addr,
   output logic      [CNT_W-1:0]          clip_wr_count,
   output logic                           clip_wr_loop,
   output logic      [AW-1:0]             dur_rd_addr,
   input  wire logic [sfs_pkg::DUR_W-1:0] dur_rd_data,
   output logic                           dur_wr_en,
   output logic      [AW-1:0]             dur_wr_addr,
   output logic      [sfs_pkg::DUR_W-1:0] dur_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCALE,
      ST_WALK,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   sfs_pkg::mode_type mode_ff, mode_in;
   logic [3:0]        active_ff, active_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [31:0]       elapsed_ff, elapsed_in;
   logic              ok_ff, ok_in;
   logic [15:0]       speed_ff, speed_in;
   logic [STEP_W-1:0] steps_ff, steps_in;

   // Latched request fields and per-tick working values.
   logic [3:0]        cmd_ff, cmd_in;
   logic [3:0]        id_ff, id_in;
   logic [5:0]        slot_ff, slot_in;
   logic [15:0]       delta_ff, delta_in;
   logic [15:0]       value_ff, value_in;
   logic              lflag_ff, lflag_in;
   logic [31:0]       prod_ff, prod_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              lp_ff, lp_in;

   logic [32:0]       sum_w;
   logic [31:0]       dur_w;
   logic [CNT_W-1:0]  frame_inc;
   logic [STEP_W-1:0] steps_inc;
   logic              id_in_range;

   assign sum_w       = {1'b0, elapsed_ff} + {9'b0, prod_ff[31:8]};
   assign dur_w       = {16'b0, dur_rd_data};
   assign frame_inc   = CNT_W'(frame_ff) + CNT_W'(1);
   assign steps_inc   = steps_ff + STEP_W'(1);
   assign id_in_range = (id_ff != 4'd0) && (32'(id_ff) < NUM_CLIPS);

   assign req.ready = (state_ff == ST_IDLE);

   // Plays look up the requested clip; everything else looks up the active one.
   assign clip_rd_addr = ((req.command == sfs_pkg::CMD_PLAY) ||
                          (req.command == sfs_pkg::CMD_PLAY_RESTART))
                         ? CLIP_W'(req.clip_id) : CLIP_W'(active_ff);

   // Addressed by the next frame position, the registered duration matches frame_ff.
   assign dur_rd_addr = base_ff + AW'(frame_in);

   assign result_valid        = (state_ff == ST_DONE);
   assign result.ok           = ok_ff;
   assign result.play_state   = mode_ff;
   assign result.current_clip = active_ff;
   assign result.frame_index  = 6'(frame_ff);
   assign result.elapsed_ms   = elapsed_ff;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      active_in  = active_ff;
      frame_in   = frame_ff;
      elapsed_in = elapsed_ff;
      ok_in      = ok_ff;
      steps_in   = steps_ff;
      speed_in   = csr_wr_en ? csr_wr_data : speed_ff;
      cmd_in     = cmd_ff;
      id_in      = id_ff;
      slot_in    = slot_ff;
      delta_in   = delta_ff;
      value_in   = value_ff;
      lflag_in   = lflag_ff;
      prod_in    = prod_ff;
      base_in    = base_ff;
      cnt_in     = cnt_ff;
      lp_in      = lp_ff;

      clip_wr_en    = 1'b0;
      clip_wr_addr  = CLIP_W'(id_ff);
      clip_wr_count = (32'(value_ff) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(value_ff);
      clip_wr_loop  = lflag_ff;
      dur_wr_en     = 1'b0;
      dur_wr_addr   = AW'(32'(id_ff) * MAX_FRAMES + 32'(slot_ff));
      dur_wr_data   = value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cmd_in   = req.command;
               id_in    = req.clip_id;
               slot_in  = req.frame_slot;
               delta_in = req.delta_ms;
               value_in = req.table_value;
               lflag_in = req.loop_flag;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ok_in    = 1'b1;
            state_in = ST_DONE;
            case (cmd_ff)
               sfs_pkg::CMD_TICK: begin
                  if ((mode_ff == sfs_pkg::MODE_PLAYING) && (active_ff != 4'd0) &&
                      (clip_rd_count != '0)) begin
                     // The clip may have been shortened under the current frame.
                     if (CNT_W'(frame_ff) >= clip_rd_count) begin
                        frame_in = FRAME_W'(clip_rd_count - CNT_W'(1));
                     end
                     prod_in  = {16'b0, delta_ff} * {16'b0, speed_ff};
                     base_in  = AW'(32'(active_ff) * MAX_FRAMES);
                     cnt_in   = clip_rd_count;
                     lp_in    = clip_rd_loop;
                     state_in = ST_SCALE;
                  end
               end
               sfs_pkg::CMD_PLAY, sfs_pkg::CMD_PLAY_RESTART: begin
                  if (!id_in_range || (clip_rd_count == '0)) begin
                     ok_in = 1'b0;
                  end else if (!((active_ff == id_ff) && (mode_ff == sfs_pkg::MODE_PLAYING) &&
                                 (cmd_ff == sfs_pkg::CMD_PLAY))) begin
                     active_in  = id_ff;
                     frame_in   = '0;
                     elapsed_in = '0;
                     mode_in    = sfs_pkg::MODE_PLAYING;
                  end
               end
               sfs_pkg::CMD_STOP: begin
                  active_in  = 4'd0;
                  mode_in    = sfs_pkg::MODE_STOPPED;
                  frame_in   = '0;
                  elapsed_in = '0;
               end
               sfs_pkg::CMD_PAUSE: begin
                  if (mode_ff == sfs_pkg::MODE_PLAYING) begin
                     mode_in = sfs_pkg::MODE_PAUSED;
                  end
               end
               sfs_pkg::CMD_RESUME: begin
                  if (mode_ff == sfs_pkg::MODE_PAUSED) begin
                     mode_in = sfs_pkg::MODE_PLAYING;
                  end
               end
               sfs_pkg::CMD_RESTART: begin
                  if (active_ff != 4'd0) begin
                     frame_in   = '0;
                     elapsed_in = '0;
                     mode_in    = sfs_pkg::MODE_PLAYING;
                  end
               end
               sfs_pkg::CMD_WRITE_DUR: begin
                  dur_wr_en = id_in_range && (32'(slot_ff) < MAX_FRAMES);
               end
               sfs_pkg::CMD_WRITE_CLIP: begin
                  clip_wr_en = id_in_range;
               end
               default: begin
               end
            endcase
         end
         ST_SCALE: begin
            // Saturating add of the scaled time; the first duration read is in flight.
            elapsed_in = sum_w[32] ? '1 : sum_w[31:0];
            steps_in   = '0;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            if (elapsed_ff < dur_w) begin
               state_in = ST_DONE;
            end else begin
               elapsed_in = elapsed_ff - dur_w;
               steps_in   = steps_inc;
               if (frame_inc >= cnt_ff) begin
                  if (lp_ff) begin
                     frame_in = '0;
                  end else begin
                     frame_in = FRAME_W'(cnt_ff - CNT_W'(1));
                     mode_in  = sfs_pkg::MODE_FINISHED;
                     state_in = ST_DONE;
                  end
               end else begin
                  frame_in = FRAME_W'(frame_inc);
               end
               if (steps_inc == STEP_W'(MAX_STEPS_PER_TICK)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (result_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      id_ff    <= id_in;
      slot_ff  <= slot_in;
      delta_ff <= delta_in;
      value_ff <= value_in;
      lflag_ff <= lflag_in;
      prod_ff  <= prod_in;
      base_ff  <= base_in;
      cnt_ff   <= cnt_in;
      lp_ff    <= lp_in;
      steps_ff <= steps_in;
      ok_ff    <= ok_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         mode_ff    <= sfs_pkg::MODE_STOPPED;
         active_ff  <= 4'd0;
         frame_ff   <= '0;
         elapsed_ff <= '0;
         speed_ff   <= sfs_pkg::SPEED_RESET;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         active_ff  <= active_in;
         frame_ff   <= frame_in;
         elapsed_ff <= elapsed_in;
         speed_ff   <= speed_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sprite_frame_sequencer_unit.sv
// Top level of the sprite frame sequencer: memories, sequencer and response register.
//
//   Channel   Direction  Handshake                Contents
//   req_chan  in         valid/ready              command, clip, slot, delta, table value, loop
//   rsp_chan  out        valid/ready              ok, play state, clip, frame, elapsed time
//   csr_*     in         write enable, no ready   playback speed, 8.8 fixed point
//
// One command is worked on at a time. Commands other than an acting tick pass from transfer
// through LOOKUP to DONE, where the response waits. An acting tick passes LOOKUP and SCALE,
// then steps one frame per cycle in WALK until the remaining time, the step cap or the end
// of a non-looping clip stops it; at most MAX_STEPS_PER_TICK steps, each one duration RAM read.
// Reset is synchronous; the clip table valid bits clear at once and the duration RAM is not
// cleared. A new request is taken while a finished response still waits in the output register.
`default_nettype none

module sprite_frame_sequencer_unit #(
   parameter int unsigned NUM_CLIPS          = 16,
   parameter int unsigned MAX_FRAMES         = 64,
   parameter int unsigned MAX_STEPS_PER_TICK = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   sfs_req_if.sink          req_chan,
   sfs_rsp_if.source        rsp_chan
);

   localparam int unsigned CLIP_W = $clog2(NUM_CLIPS);
   localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int unsigned DEPTH  = NUM_CLIPS * MAX_FRAMES;
   localparam int unsigned AW     = $clog2(DEPTH);

   logic [CLIP_W-1:0]         clip_rd_addr;
   logic [CNT_W-1:0]          clip_rd_count;
   logic                      clip_rd_loop;
   logic                      clip_wr_en;
   logic [CLIP_W-1:0]         clip_wr_addr;
   logic [CNT_W-1:0]          clip_wr_count;
   logic                      clip_wr_loop;
   logic [AW-1:0]             dur_rd_addr;
   logic [sfs_pkg::DUR_W-1:0] dur_rd_data;
   logic                      dur_wr_en;
   logic [AW-1:0]             dur_wr_addr;
   logic [sfs_pkg::DUR_W-1:0] dur_wr_data;

   logic                      result_valid;
   sfs_pkg::rsp_type          result;
   logic                      result_load;
   logic                      rsp_valid_ff, rsp_valid_in;
   sfs_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   sfs_clip_mem #(
      .NUM_CLIPS (NUM_CLIPS),
      .MAX_FRAMES(MAX_FRAMES)
   ) u_clip_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (clip_rd_addr),
      .rd_count(clip_rd_count),
      .rd_loop (clip_rd_loop),
      .wr_en   (clip_wr_en),
      .wr_addr (clip_wr_addr),
      .wr_count(clip_wr_count),
      .wr_loop (clip_wr_loop)
   );

   sfs_dur_mem #(
      .DEPTH(DEPTH)
   ) u_dur_mem (
      .clock  (clock),
      .rd_addr(dur_rd_addr),
      .rd_data(dur_rd_data),
      .wr_en  (dur_wr_en),
      .wr_addr(dur_wr_addr),
      .wr_data(dur_wr_data)
   );

   sfs_ctrl #(
      .NUM_CLIPS         (NUM_CLIPS),
      .MAX_FRAMES        (MAX_FRAMES),
      .MAX_STEPS_PER_TICK(MAX_STEPS_PER_TICK)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req          (req_chan),
      .result_valid (result_valid),
      .result       (result),
      .result_load  (result_load),
      .clip_rd_addr (clip_rd_addr),
      .clip_rd_count(clip_rd_count),
      .clip_rd_loop (clip_rd_loop),
      .clip_wr_en   (clip_wr_en),
      .clip_wr_addr (clip_wr_addr),
      .clip_wr_count(clip_wr_count),
      .clip_wr_loop (clip_wr_loop),
      .dur_rd_addr  (dur_rd_addr),
      .dur_rd_data  (dur_rd_data),
      .dur_wr_en    (dur_wr_en),
      .dur_wr_addr  (dur_wr_addr),
      .dur_wr_data  (dur_wr_data)
   );

   // The output register takes a new response when it is empty or its transfer completes.
   assign result_load  = result_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = result_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in  = result_load ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.ok           = rsp_data_ff.ok;
   assign rsp_chan.play_state   = rsp_data_ff.play_state;
   assign rsp_chan.current_clip = rsp_data_ff.current_clip;
   assign rsp_chan.frame_index  = rsp_data_ff.frame_index;
   assign rsp_chan.elapsed_ms   = rsp_data_ff.elapsed_ms;

endmodule

`default_nettype wire
